// ----- hdl/plg_pkg.sv -----
// ----------------------------------------------------------------------------
// plg_pkg
// Shared constants, the quarter-wave sine table and the pipeline control
// struct of the plasma pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package plg_pkg;

  localparam int COL_W   = 8;
  localparam int ROW_W   = 7;
  localparam int TIME_W  = 32;
  localparam int COLOR_W = 16;
  localparam int PHASE_W = 16;
  localparam int WAVE_W  = 16;
  localparam int ROM_W   = 15;
  localparam int ROM_IDX_W = 8;
  localparam int FRAC_W  = 7;
  localparam int LANES   = 4;

  // phase multipliers
  localparam logic [15:0] MUL_COL  = 16'd1234;
  localparam logic [15:0] MUL_ROW  = 16'd1432;
  localparam logic [18:0] MUL_DIFF = 19'd5678;
  localparam logic [17:0] MUL_SUM  = 18'd2768;

  localparam logic [WAVE_W-1:0] WAVE_MID = 16'h7FFF;
  localparam logic [7:0]        FRAC_ONE = 8'h80;
  localparam logic [ROM_IDX_W-1:0] ROM_LAST = 8'd128;

  localparam logic [ROM_W-1:0] WAVE_ROM [129] = '{
    15'h0000, 15'h0195, 15'h032A, 15'h04BF, 15'h0654, 15'h07E9, 15'h097D, 15'h0B11,
    15'h0CA4, 15'h0E37, 15'h0FCA, 15'h115C, 15'h12ED, 15'h147D, 15'h160D, 15'h179C,
    15'h192A, 15'h1AB7, 15'h1C42, 15'h1DCD, 15'h1F57, 15'h20DF, 15'h2266, 15'h23EC,
    15'h2570, 15'h26F3, 15'h2874, 15'h29F4, 15'h2B72, 15'h2CEE, 15'h2E69, 15'h2FE2,
    15'h3158, 15'h32CD, 15'h3440, 15'h35B1, 15'h3720, 15'h388D, 15'h39F7, 15'h3B5F,
    15'h3CC5, 15'h3E29, 15'h3F8A, 15'h40E8, 15'h4244, 15'h439E, 15'h44F5, 15'h4649,
    15'h479A, 15'h48E9, 15'h4A34, 15'h4B7D, 15'h4CC3, 15'h4E06, 15'h4F45, 15'h5082,
    15'h51BB, 15'h52F2, 15'h5425, 15'h5554, 15'h5681, 15'h57AA, 15'h58CF, 15'h59F2,
    15'h5B10, 15'h5C2B, 15'h5D43, 15'h5E56, 15'h5F66, 15'h6073, 15'h617B, 15'h6280,
    15'h6381, 15'h647E, 15'h6577, 15'h666C, 15'h675D, 15'h684A, 15'h6933, 15'h6A18,
    15'h6AF8, 15'h6BD5, 15'h6CAD, 15'h6D81, 15'h6E50, 15'h6F1C, 15'h6FE3, 15'h70A5,
    15'h7164, 15'h721D, 15'h72D3, 15'h7384, 15'h7430, 15'h74D8, 15'h757B, 15'h7619,
    15'h76B3, 15'h7749, 15'h77D9, 15'h7865, 15'h78EC, 15'h796F, 15'h79EC, 15'h7A65,
    15'h7ADA, 15'h7B49, 15'h7BB3, 15'h7C19, 15'h7C7A, 15'h7CD6, 15'h7D2D, 15'h7D7F,
    15'h7DCC, 15'h7E14, 15'h7E58, 15'h7E96, 15'h7ED0, 15'h7F04, 15'h7F34, 15'h7F5E,
    15'h7F84, 15'h7FA4, 15'h7FC0, 15'h7FD6, 15'h7FE8, 15'h7FF4, 15'h7FFC, 15'h7FFF,
    15'h7FFF
  };

  function automatic logic [ROM_W-1:0] wave_lut(input logic [ROM_IDX_W-1:0] idx);
    logic [ROM_W-1:0] val;
    val = '0;
    if (idx <= ROM_LAST) begin
      val = WAVE_ROM[idx];
    end
    return val;
  endfunction

  // load enables of the three payload stages ahead of the output register
  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_s3;
  } plg_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/plg_coord_if.sv -----
// ----------------------------------------------------------------------------
// plg_coord_if
// Pixel coordinate and time channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface plg_coord_if;
  logic                         valid;
  logic                         ready;
  logic [plg_pkg::COL_W-1:0]    pixel_col;
  logic [plg_pkg::ROW_W-1:0]    pixel_row;
  logic [plg_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, output pixel_col, output pixel_row, output time_ms,
                  input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input time_ms,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/plg_color_if.sv -----
// ----------------------------------------------------------------------------
// plg_color_if
// RGB565 pixel channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface plg_color_if;
  logic                          valid;
  logic                          ready;
  logic [plg_pkg::COLOR_W-1:0]   pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

// ----- hdl/plg_phase.sv -----
// ----------------------------------------------------------------------------
// plg_phase
// Stage 1: forms the four 16-bit wave phases from column, row and time.
// ----------------------------------------------------------------------------
`default_nettype none

module plg_phase (
  input  wire logic                                       clk,
  input  wire plg_pkg::plg_ctrl_t                         ctrl,
  input  wire logic [plg_pkg::COL_W-1:0]                  pixel_col,
  input  wire logic [plg_pkg::ROW_W-1:0]                  pixel_row,
  input  wire logic [plg_pkg::TIME_W-1:0]                 time_ms,
  output logic [plg_pkg::LANES-1:0][plg_pkg::PHASE_W-1:0] phase
);

  logic [15:0] p1_next;
  logic [15:0] p2_next;
  logic [18:0] diff;
  logic [18:0] p3_full;
  logic [17:0] p4_full;
  logic [8:0]  sum;

  // t = time << 2, so the time terms are slices of time_ms
  always_comb begin
    p1_next = 16'(16'(pixel_col) * plg_pkg::MUL_COL) + {time_ms[13:0], 2'b00};
    p2_next = 16'(16'(pixel_row) * plg_pkg::MUL_ROW) - {time_ms[12:0], 3'b000};
    // only the low 19 bits of the difference product reach bits 18:3
    diff    = 19'(pixel_col) - 19'(pixel_row);
    p3_full = 19'(diff * plg_pkg::MUL_DIFF) - time_ms[18:0];
    sum     = 9'(pixel_col) + 9'(pixel_row);
    p4_full = 18'(18'(sum) * plg_pkg::MUL_SUM) + time_ms[18:1];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      phase[0] <= p1_next;
      phase[1] <= p2_next;
      phase[2] <= p3_full[18:3];
      phase[3] <= p4_full[17:2];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/plg_wave.sv -----
// ----------------------------------------------------------------------------
// plg_wave
// Stages 2 and 3 of one lane: quarter-wave table lookup with mirroring, then
// linear interpolation and the half-wave sign.
// ----------------------------------------------------------------------------
`default_nettype none

module plg_wave (
  input  wire logic                            clk,
  input  wire plg_pkg::plg_ctrl_t              ctrl,
  input  wire logic [plg_pkg::PHASE_W-1:0]     phase,
  output logic [plg_pkg::WAVE_W-1:0]           wave
);

  logic [6:0]                   idx;
  logic [plg_pkg::FRAC_W-1:0]   frac_next;
  logic [plg_pkg::ROM_W-1:0]    lo_val;
  logic [plg_pkg::ROM_W-1:0]    hi_val;
  logic [plg_pkg::FRAC_W-1:0]   frac;
  logic                         neg;
  logic [22:0]                  interp;
  logic [14:0]                  mag;
  logic [plg_pkg::WAVE_W-1:0]   wave_next;

  // second and fourth quarters run the table backwards
  always_comb begin
    if (phase[14]) begin
      idx       = ~phase[13:7];
      frac_next = ~phase[6:0];
    end else begin
      idx       = phase[13:7];
      frac_next = phase[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s2) begin
      lo_val <= plg_pkg::wave_lut({1'b0, idx});
      hi_val <= plg_pkg::wave_lut(8'({1'b0, idx}) + 8'd1);
      frac   <= frac_next;
      neg    <= phase[15];
    end
  end

  always_comb begin
    interp = 23'(lo_val) * 23'(plg_pkg::FRAC_ONE - 8'(frac)) + 23'(hi_val) * 23'(frac);
    mag    = interp[21:7];
    if (neg) begin
      wave_next = plg_pkg::WAVE_MID - 16'(mag);
    end else begin
      wave_next = plg_pkg::WAVE_MID + 16'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s3) begin
      wave <= wave_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/plasma_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// plasma_pixel_generator
// Turns a pixel coordinate and a millisecond time into one RGB565 pixel of a
// moving plasma pattern.
//
// Channels: coord takes one beat per pixel (pixel_col, pixel_row, time_ms);
// pixel gives one beat per accepted coord beat (pixel_color), in order.
// Throughput: one pixel per clock with the receiver ready.
// Pipeline: four register stages (phases, table lookup, interpolation, sum and
// pack); each accepted coord beat passes through them in that order to pixel.
// Each stage holds its beat while the stage after it is full and not moving,
// so a stalled receiver fills the pipeline from the output backwards; coord
// ready falls only once all four stages hold a beat.
// Reset clears the stage valid bits; the pattern itself has no state.
// ----------------------------------------------------------------------------
`default_nettype none

module plasma_pixel_generator (
  input  wire logic   clk,
  input  wire logic   rst,
  plg_coord_if.sink   coord,
  plg_color_if.source pixel
);

  logic v1;
  logic v2;
  logic v3;
  logic v4;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;

  plg_pkg::plg_ctrl_t ctrl;

  logic [plg_pkg::LANES-1:0][plg_pkg::PHASE_W-1:0] phase;
  logic [plg_pkg::LANES-1:0][plg_pkg::WAVE_W-1:0]  wave;
  logic [17:0]                                     wave_sum;
  logic [7:0]                                      level;
  logic [plg_pkg::COLOR_W-1:0]                     color_next;
  logic [plg_pkg::COLOR_W-1:0]                     color;

  // a stage may load when it is empty or its beat moves on
  always_comb begin
    rdy4         = !v4 || pixel.ready;
    rdy3         = !v3 || rdy4;
    rdy2         = !v2 || rdy3;
    rdy1         = !v1 || rdy2;
    ctrl.load_s1 = rdy1;
    ctrl.load_s2 = rdy2;
    ctrl.load_s3 = rdy3;
  end

  assign coord.ready       = rdy1;
  assign pixel.valid       = v4;
  assign pixel.pixel_color = color;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= coord.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  plg_phase u_phase (
    .clk       (clk),
    .ctrl      (ctrl),
    .pixel_col (coord.pixel_col),
    .pixel_row (coord.pixel_row),
    .time_ms   (coord.time_ms),
    .phase     (phase)
  );

  for (genvar i = 0; i < plg_pkg::LANES; i++) begin : g_lane
    plg_wave u_wave (
      .clk   (clk),
      .ctrl  (ctrl),
      .phase (phase[i]),
      .wave  (wave[i])
    );
  end

  // low field packs level>>2 and level>>3 unshifted
  always_comb begin
    wave_sum   = 18'(wave[0]) + 18'(wave[1]) + 18'(wave[2]) + 18'(wave[3]);
    level      = wave_sum[17:10];
    color_next = {level[7:3], 11'd0} | 16'(level[7:2]) | 16'(level[7:3]);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      color <= color_next;
    end
  end

  // input stalls only with every stage occupied
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !coord.ready |-> (v1 && v2 && v3 && v4))
    else $error("coord stalled with an empty stage");

  // an output beat can only come out of the interpolation stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(v4) |-> $past(v3))
    else $error("output valid without a beat behind it");

  // each wave value stays within 0..0xFFFE
  a_wave_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (wave[0] != 16'hFFFF && wave[1] != 16'hFFFF &&
            wave[2] != 16'hFFFF && wave[3] != 16'hFFFF))
    else $error("wave value out of range");

endmodule

`default_nettype wire
